/* design/hmp_track_to_midi_converter_assert.svh */
`ifndef HMP_TRACK_TO_MIDI_CONVERTER_ASSERT_SVH
`define HMP_TRACK_TO_MIDI_CONVERTER_ASSERT_SVH

`ifndef ASSERT_OFF
`define HMP_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define HMP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define HMP_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define HMP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

/* design/hmp_pkg.sv */
package hmp_pkg;

  localparam int MaxDeltaBytes = 4;
  localparam int GroupSlots    = MaxDeltaBytes - 1;
  localparam int CountWidth    = 24;
  localparam int TrackBytesW   = 24;
  localparam int StatusW       = 3;
  localparam int DcW           = $clog2(GroupSlots + 1);
  localparam int NbW           = $clog2(MaxDeltaBytes + 1);
  localparam int IdxW          = $clog2(MaxDeltaBytes);
  localparam int OutPackW      = 8 + StatusW + TrackBytesW;
  localparam int OutDataW      = ((OutPackW + 7) / 8) * 8;

  localparam logic [CountWidth-1:0] CountMax = '1;

  localparam logic [7:0] MetaByte   = 8'hFF;
  localparam logic [7:0] MetaEndTyp = 8'h2F;

  typedef enum logic [2:0] {
    PH_DELTA = 3'd0,
    PH_EVENT = 3'd1,
    PH_CHAN  = 3'd2,
    PH_MTYPE = 3'd3,
    PH_MLEN  = 3'd4,
    PH_MBODY = 3'd5,
    PH_HALT  = 3'd6
  } phase_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK         = 3'd0,
    ST_DONE       = 3'd1,
    ST_DELTA_LONG = 3'd2,
    ST_BAD_STATUS = 3'd3,
    ST_TRUNC      = 3'd4
  } status_e;

  typedef struct packed {
    logic       tend;
    logic       first;
    logic [7:0] data;
  } in_item_t;

  typedef struct packed {
    logic [MaxDeltaBytes-1:0][7:0] bytes;
    logic [NbW-1:0]                nbytes;
    status_e                       status;
    logic [CountWidth-1:0]         base;
  } bundle_t;

  function automatic logic [TrackBytesW-1:0] to_track_bytes(logic [CountWidth-1:0] c);
    logic [63:0] w;
    w = 64'(c);
    return w[TrackBytesW-1:0];
  endfunction

endpackage

/* design/hmp_parser.sv */
module hmp_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  hmp_pkg::in_item_t item_i,
  output hmp_pkg::bundle_t  res_o
);
  import hmp_pkg::*;

  phase_e                 phase_q, phase_d;
  status_e                halt_q, halt_d;
  logic [DcW-1:0]         dc_q, dc_d;
  logic [7:0]             prev_q, prev_d;
  logic [1:0]             dbl_q, dbl_d;
  logic [7:0]             mbl_q, mbl_d;
  logic                   mie_q, mie_d;
  logic [CountWidth-1:0]  cnt_q, cnt_d;
  logic [GroupSlots-1:0][6:0] grp_q;

  phase_e                 ph_e;
  status_e                halt_e, st;
  logic [DcW-1:0]         dc_e;
  logic [7:0]             prev_e, b;
  logic [1:0]             dbl_e;
  logic [7:0]             mbl_e;
  logic                   mie_e;
  logic [CountWidth-1:0]  cnt_e;
  logic [NbW-1:0]         n;
  logic [MaxDeltaBytes-1:0][7:0] bytes;
  logic                   grp_shift;
  logic [1:0]             chan_n;
  logic [CountWidth:0]    sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_DELTA;
      halt_q  <= ST_OK;
      dc_q    <= '0;
      prev_q  <= '0;
      dbl_q   <= '0;
      mbl_q   <= '0;
      mie_q   <= 1'b0;
      cnt_q   <= '0;
    end else if (en_i) begin
      phase_q <= phase_d;
      halt_q  <= halt_d;
      dc_q    <= dc_d;
      prev_q  <= prev_d;
      dbl_q   <= dbl_d;
      mbl_q   <= mbl_d;
      mie_q   <= mie_d;
      cnt_q   <= cnt_d;
    end
  end

  // shift in delta groups, newest at slot zero
  always_ff @(posedge clk_i) begin
    if (en_i && grp_shift) begin
      grp_q[0] <= b[6:0];
      for (int i = 1; i < GroupSlots; i++) begin
        grp_q[i] <= grp_q[i-1];
      end
    end
  end

  always_comb begin
    b      = item_i.data;
    ph_e   = item_i.first ? PH_DELTA : phase_q;
    halt_e = item_i.first ? ST_OK : halt_q;
    dc_e   = item_i.first ? '0 : dc_q;
    prev_e = item_i.first ? '0 : prev_q;
    dbl_e  = item_i.first ? '0 : dbl_q;
    mbl_e  = item_i.first ? '0 : mbl_q;
    mie_e  = item_i.first ? 1'b0 : mie_q;
    cnt_e  = item_i.first ? '0 : cnt_q;

    phase_d   = ph_e;
    halt_d    = halt_e;
    dc_d      = dc_e;
    prev_d    = prev_e;
    dbl_d     = dbl_e;
    mbl_d     = mbl_e;
    mie_d     = mie_e;
    st        = ST_OK;
    n         = '0;
    bytes     = '0;
    grp_shift = 1'b0;
    chan_n    = 2'd0;

    if (b[7:4] inside {4'h8, 4'h9, 4'hA, 4'hB, 4'hE}) begin
      chan_n = 2'd2;
    end else if (b[7:4] inside {4'hC, 4'hD}) begin
      chan_n = 2'd1;
    end

    case (ph_e)
      PH_HALT: begin
        st = halt_e;
      end
      PH_DELTA: begin
        if (b[7]) begin
          bytes[0] = {dc_e != '0, b[6:0]};
          for (int j = 1; j <= GroupSlots; j++) begin
            bytes[j] = {DcW'(j) < dc_e, grp_q[j-1]};
          end
          n       = NbW'(dc_e) + NbW'(1);
          dc_d    = '0;
          phase_d = PH_EVENT;
        end else if (dc_e >= DcW'(GroupSlots)) begin
          st = ST_DELTA_LONG;
        end else begin
          grp_shift = 1'b1;
          dc_d      = dc_e + DcW'(1);
        end
      end
      PH_EVENT: begin
        if (b == MetaByte) begin
          bytes[0] = b;
          n        = NbW'(1);
          phase_d  = PH_MTYPE;
        end else if (!b[7] || chan_n == 2'd0) begin
          st = ST_BAD_STATUS;
        end else begin
          if (b != prev_e) begin
            bytes[0] = b;
            n        = NbW'(1);
          end
          prev_d  = b;
          dbl_d   = chan_n;
          phase_d = PH_CHAN;
        end
      end
      PH_CHAN: begin
        bytes[0] = b;
        n        = NbW'(1);
        if (dbl_e != 2'd0) begin
          dbl_d = dbl_e - 2'd1;
        end
        if (dbl_d == 2'd0) begin
          phase_d = PH_DELTA;
        end
      end
      PH_MTYPE: begin
        bytes[0] = b;
        n        = NbW'(1);
        mie_d    = (b == MetaEndTyp);
        phase_d  = PH_MLEN;
      end
      PH_MLEN: begin
        bytes[0] = b;
        n        = NbW'(1);
        mbl_d    = b;
        phase_d  = (b == 8'd0) ? PH_DELTA : PH_MBODY;
        if (b == 8'd0 && mie_e) begin
          st = ST_DONE;
        end
      end
      PH_MBODY: begin
        bytes[0] = b;
        n        = NbW'(1);
        if (mbl_e != 8'd0) begin
          mbl_d = mbl_e - 8'd1;
        end
        if (mbl_d == 8'd0) begin
          phase_d = PH_DELTA;
          if (mie_e) begin
            st = ST_DONE;
          end
        end
      end
      default: begin
        st = halt_e;
      end
    endcase

    if (ph_e != PH_HALT) begin
      if (st == ST_OK && item_i.tend) begin
        st = (phase_d == PH_DELTA && dc_d == '0) ? ST_DONE : ST_TRUNC;
      end
      if (st != ST_OK) begin
        phase_d = PH_HALT;
        halt_d  = st;
      end
    end

    sum   = {1'b0, cnt_e} + (CountWidth + 1)'(n);
    cnt_d = (sum > {1'b0, CountMax}) ? CountMax : sum[CountWidth-1:0];

    res_o.bytes  = bytes;
    res_o.nbytes = n;
    res_o.status = st;
    res_o.base   = cnt_e;
  end

endmodule

/* design/hmp_track_to_midi_converter.sv */
// Accepted input words are registered in in_q; their results are registered in bnd_q.
// While m_axis_tready is high, one input word per cycle while each word yields at
// most one result; a delta terminator yields up to four result words, one per cycle,
// and holds the input side while the output register drains.
// Reset: rst_ni is asynchronous, active low, and clears the parser state.
`include "hmp_track_to_midi_converter_assert.svh"

module hmp_track_to_midi_converter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,  // in_byte
  input  logic                         s_axis_tuser,  // first_of_track
  input  logic                         s_axis_tlast,  // track_end
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [hmp_pkg::OutDataW-1:0] m_axis_tdata,  // out_byte, status, track_bytes
  output logic                         m_axis_tuser,  // byte_valid
  output logic                         m_axis_tlast   // last
);
  import hmp_pkg::*;

  logic                  in_valid_q, in_valid_d;
  in_item_t              in_q;
  bundle_t               res, bnd_q;
  logic                  bvalid_q, bvalid_d;
  logic [IdxW-1:0]       idx_q, idx_d;
  logic                  commit, produce, pop, last_item, last_pop, bnd_free;
  logic [CountWidth:0]   osum;
  logic [CountWidth-1:0] ocnt;
  logic [7:0]            obyte;

  hmp_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (commit),
    .item_i (in_q),
    .res_o  (res)
  );

  assign last_item = (bnd_q.nbytes == '0) || (NbW'(idx_q) + NbW'(1) == bnd_q.nbytes);
  assign pop       = bvalid_q && m_axis_tready;
  assign last_pop  = pop && last_item;
  assign bnd_free  = !bvalid_q || last_pop;
  assign commit    = in_valid_q && bnd_free;
  assign produce   = (res.nbytes != '0) || (res.status != ST_OK);

  assign s_axis_tready = !in_valid_q || commit;

  always_comb begin
    in_valid_d = in_valid_q;
    if (commit) begin
      in_valid_d = 1'b0;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      in_valid_d = 1'b1;
    end
    bvalid_d = bvalid_q;
    idx_d    = idx_q;
    if (commit) begin
      bvalid_d = produce;
      idx_d    = '0;
    end else if (last_pop) begin
      bvalid_d = 1'b0;
    end else if (pop) begin
      idx_d = idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      bvalid_q   <= 1'b0;
      idx_q      <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      bvalid_q   <= bvalid_d;
      idx_q      <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q <= '{tend: s_axis_tlast, first: s_axis_tuser, data: s_axis_tdata};
    end
    if (commit && produce) begin
      bnd_q <= res;
    end
  end

  always_comb begin
    osum  = {1'b0, bnd_q.base} + (CountWidth + 1)'(idx_q) + (CountWidth + 1)'(1);
    obyte = 8'd0;
    ocnt  = bnd_q.base;
    if (bnd_q.nbytes != '0) begin
      obyte = bnd_q.bytes[idx_q];
      ocnt  = (osum > {1'b0, CountMax}) ? CountMax : osum[CountWidth-1:0];
    end
  end

  assign m_axis_tvalid = bvalid_q;
  assign m_axis_tuser  = (bnd_q.nbytes != '0);
  assign m_axis_tlast  = last_item;
  assign m_axis_tdata  = {(OutDataW - OutPackW)'(0), to_track_bytes(ocnt), bnd_q.status, obyte};

  `HMP_ASSERT_IMPL(a_bundle_size, clk_i, rst_ni, bvalid_q, bnd_q.nbytes <= NbW'(MaxDeltaBytes), "result bundle exceeds the delta byte limit")
  `HMP_ASSERT_IMPL(a_status_only_last, clk_i, rst_ni, bvalid_q && !m_axis_tuser, m_axis_tlast, "status-only word without last")
  `HMP_ASSERT_NEXT(a_bundle_continues, clk_i, rst_ni, pop && !last_item, bvalid_q && m_axis_tuser, "bundle drained before its last word")
  `HMP_ASSERT_IMPL(a_no_commit_busy, clk_i, rst_ni, commit, !bvalid_q || last_pop, "parser committed while the output register was busy")

endmodule
